// File: hw/rtl/trpa_pkg.sv
// shared word types and field widths for the triangle perimeter and area core
package trpa_pkg;

  localparam int FIELD_W = 16;
  localparam int PERIM_W = 20;
  localparam int AREA_W  = 24;

  // one triangle: three vertices, signed fixed point
  typedef struct packed {
    logic signed [FIELD_W-1:0] first_x;
    logic signed [FIELD_W-1:0] first_y;
    logic signed [FIELD_W-1:0] second_x;
    logic signed [FIELD_W-1:0] second_y;
    logic signed [FIELD_W-1:0] third_x;
    logic signed [FIELD_W-1:0] third_y;
  } tri_word_t;

  // one result: perimeter and heron area, unsigned fixed point
  typedef struct packed {
    logic [PERIM_W-1:0] perimeter;
    logic [AREA_W-1:0]  area;
  } res_word_t;

endpackage

// File: hw/rtl/trpa_sqrt_cell.sv
// one digit cell of a pipelined square root: two radicand bits in, one root bit out
module trpa_sqrt_cell #(
  parameter int RAD_W = 34,
  parameter int LANES = 3
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 valid_in,
  input  logic [LANES-1:0][RAD_W-1:0]          rad_in,
  input  logic [LANES-1:0][RAD_W/2+1:0]        rem_in,
  input  logic [LANES-1:0][RAD_W/2-1:0]        root_in,
  output logic                                 valid_out,
  output logic [LANES-1:0][RAD_W-1:0]          rad_out,
  output logic [LANES-1:0][RAD_W/2+1:0]        rem_out,
  output logic [LANES-1:0][RAD_W/2-1:0]        root_out
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  logic [LANES-1:0][RAD_W-1:0]  rad_next;
  logic [LANES-1:0][REM_W-1:0]  rem_next;
  logic [LANES-1:0][ROOT_W-1:0] root_next;

  // bring down two bits, try root*4+1 against the partial remainder
  always_comb begin
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    for (int l = 0; l < LANES; l++) begin
      rem_sh = {rem_in[l][REM_W-3:0], rad_in[l][RAD_W-1:RAD_W-2]};
      trial  = {root_in[l], 2'b01};
      rad_next[l] = {rad_in[l][RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_next[l]  = rem_sh - trial;
        root_next[l] = {root_in[l][ROOT_W-2:0], 1'b1};
      end else begin
        rem_next[l]  = rem_sh;
        root_next[l] = {root_in[l][ROOT_W-2:0], 1'b0};
      end
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  // digit state handed to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= rad_next;
      rem_out  <= rem_next;
      root_out <= root_next;
    end
  end

endmodule

// File: hw/rtl/triangle_perimeter_area_core.sv
// triangle perimeter and heron area core: front end, two square root cell chains, product stages, output
//
// Usage: the tri channel (tri_valid, tri_stall, tri_word) carries one triangle word,
// three vertices in signed fixed point with FRAC_BITS fraction bits. The res channel
// (res_valid, res_stall, res_word) returns one word per triangle: the sum of the three
// truncated side lengths and the truncated heron area, both with FRAC_BITS fraction bits.
// A word is taken when valid is high and stall is low.
// Throughput is one triangle per cycle while res_stall does not hold the pipe. From
// acceptance to res_valid a triangle passes three front end stages, a chain of
// COORD_WIDTH+1 side root cells, four product stages, a chain of 2*COORD_WIDTH+6
// area root cells, each giving one root bit, and the output register.
// The whole pipe advances together; while res_valid is high and res_stall is high it
// holds, tri_stall is raised and the result word stays put.
// Reset (rst, synchronous) clears all valid flags; no state carries between triangles.
module triangle_perimeter_area_core #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                tri_valid,
  output logic                tri_stall,
  input  trpa_pkg::tri_word_t tri_word,
  output logic                res_valid,
  input  logic                res_stall,
  output trpa_pkg::res_word_t res_word
);

  localparam int W          = COORD_WIDTH;
  localparam int FW         = trpa_pkg::FIELD_W;
  localparam int SQ_W       = 2 * W;
  localparam int RAD1_W     = 2 * W + 2;
  localparam int SIDE_CELLS = RAD1_W / 2;
  localparam int SW         = RAD1_W / 2;
  localparam int PW         = SW + 2;
  localparam int MW         = 2 * PW;
  localparam int PPW        = 3 * PW;
  localparam int RAD2_W     = 4 * PW;
  localparam int AREA_CELLS = RAD2_W / 2;
  localparam int AW         = RAD2_W / 2;
  localparam int PERIM_W    = trpa_pkg::PERIM_W;
  localparam int AREA_W     = trpa_pkg::AREA_W;

  logic en;

  // pipe moves unless the result register is full and held
  assign en        = !(res_valid && res_stall);
  assign tri_stall = !en;

  // coordinates cut to COORD_WIDTH bits
  logic [FW-1:0] fld [6];
  logic [W-1:0]  crd [6];

  assign fld[0] = tri_word.first_x;
  assign fld[1] = tri_word.first_y;
  assign fld[2] = tri_word.second_x;
  assign fld[3] = tri_word.second_y;
  assign fld[4] = tri_word.third_x;
  assign fld[5] = tri_word.third_y;

  always_comb begin
    logic [W+FW-1:0] ext;
    for (int i = 0; i < 6; i++) begin
      ext    = (W + FW)'(fld[i]);
      crd[i] = ext[W-1:0];
    end
  end

  // absolute coordinate differences for sides first-second, second-third, third-first
  logic [2:0][1:0][W-1:0] adiff_next;

  always_comb begin
    logic [W:0] d;
    int p;
    int q;
    for (int k = 0; k < 3; k++) begin
      p = k;
      q = (k == 2) ? 0 : k + 1;
      for (int j = 0; j < 2; j++) begin
        d = {crd[2*p+j][W-1], crd[2*p+j]} - {crd[2*q+j][W-1], crd[2*q+j]};
        if (d[W]) begin
          d = -d;
        end
        adiff_next[k][j] = d[W-1:0];
      end
    end
  end

  logic                   v1;
  logic [2:0][1:0][W-1:0] adiff;
  logic                   v2;
  logic [2:0][1:0][SQ_W-1:0] sq;
  logic                   v3;
  logic [2:0][RAD1_W-1:0] rad3;

  // front end valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= tri_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // differences, squares, sums of squares
  always_ff @(posedge clk) begin
    if (en) begin
      adiff <= adiff_next;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 2; j++) begin
          sq[k][j] <= SQ_W'(adiff[k][j]) * SQ_W'(adiff[k][j]);
        end
        rad3[k] <= RAD1_W'(sq[k][0]) + RAD1_W'(sq[k][1]);
      end
    end
  end

  // side length root chain, three lanes per cell
  logic                   side_v    [SIDE_CELLS+1];
  logic [2:0][RAD1_W-1:0] side_rad  [SIDE_CELLS+1];
  logic [2:0][SW+1:0]     side_rem  [SIDE_CELLS+1];
  logic [2:0][SW-1:0]     side_root [SIDE_CELLS+1];

  assign side_v[0]    = v3;
  assign side_rad[0]  = rad3;
  assign side_rem[0]  = '0;
  assign side_root[0] = '0;

  for (genvar c = 0; c < SIDE_CELLS; c++) begin : g_side
    trpa_sqrt_cell #(
      .RAD_W (RAD1_W),
      .LANES (3)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (side_v[c]),
      .rad_in    (side_rad[c]),
      .rem_in    (side_rem[c]),
      .root_in   (side_root[c]),
      .valid_out (side_v[c+1]),
      .rad_out   (side_rad[c+1]),
      .rem_out   (side_rem[c+1]),
      .root_out  (side_root[c+1])
    );
  end

  // perimeter terms for heron and the degenerate test
  logic [PW-1:0]       s_next;
  logic [2:0][PW-1:0]  fabs_next;
  logic                bad_next;

  always_comb begin
    logic [PW:0] f;
    logic        neg;
    logic        zero;
    s_next = PW'(side_root[SIDE_CELLS][0]) + PW'(side_root[SIDE_CELLS][1])
           + PW'(side_root[SIDE_CELLS][2]);
    neg  = 1'b0;
    zero = (s_next == '0);
    for (int k = 0; k < 3; k++) begin
      f    = (PW + 1)'(s_next) - (PW + 1)'({side_root[SIDE_CELLS][k], 1'b0});
      neg  = neg ^ f[PW];
      zero = zero | (f == '0);
      if (f[PW]) begin
        f = -f;
      end
      fabs_next[k] = f[PW-1:0];
    end
    bad_next = neg | zero;
  end

  logic               v4, v5, v6, v7;
  logic [PW-1:0]      s4, s5, s6, s7;
  logic [2:0][PW-1:0] fabs4;
  logic               bad4;
  logic [MW-1:0]      m1, m2;
  logic [PPW-1:0]     pp_lo, pp_hi;
  logic [RAD2_W-1:0]  prod;

  // product stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v4 <= side_v[SIDE_CELLS];
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  // heron product: two pair products, split partial products, final sum
  always_ff @(posedge clk) begin
    if (en) begin
      s4    <= s_next;
      fabs4 <= fabs_next;
      bad4  <= bad_next;
      s5    <= s4;
      m1    <= bad4 ? '0 : MW'(s4) * MW'(fabs4[0]);
      m2    <= MW'(fabs4[1]) * MW'(fabs4[2]);
      s6    <= s5;
      pp_lo <= PPW'(m1) * PPW'(m2[PW-1:0]);
      pp_hi <= PPW'(m1) * PPW'(m2[MW-1:PW]);
      s7    <= s6;
      prod  <= RAD2_W'(pp_lo) + (RAD2_W'(pp_hi) << PW);
    end
  end

  // area root chain with the perimeter riding alongside
  logic                    area_v    [AREA_CELLS+1];
  logic [0:0][RAD2_W-1:0]  area_rad  [AREA_CELLS+1];
  logic [0:0][AW+1:0]      area_rem  [AREA_CELLS+1];
  logic [0:0][AW-1:0]      area_root [AREA_CELLS+1];
  logic [AREA_CELLS-1:0][PW-1:0] perim_pipe;

  assign area_v[0]    = v7;
  assign area_rad[0]  = prod;
  assign area_rem[0]  = '0;
  assign area_root[0] = '0;

  for (genvar c = 0; c < AREA_CELLS; c++) begin : g_area
    trpa_sqrt_cell #(
      .RAD_W (RAD2_W),
      .LANES (1)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (area_v[c]),
      .rad_in    (area_rad[c]),
      .rem_in    (area_rem[c]),
      .root_in   (area_root[c]),
      .valid_out (area_v[c+1]),
      .rad_out   (area_rad[c+1]),
      .rem_out   (area_rem[c+1]),
      .root_out  (area_root[c+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      perim_pipe <= {perim_pipe[AREA_CELLS-2:0], s7};
    end
  end

  // scale and fit the result fields
  logic [PW+PERIM_W-1:0] perim_ext;
  logic [AW+AREA_W-1:0]  area_ext;

  assign perim_ext = (PW + PERIM_W)'(perim_pipe[AREA_CELLS-1]);
  assign area_ext  = (AW + AREA_W)'(area_root[AREA_CELLS][0]) >> (FRAC_BITS + 2);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= area_v[AREA_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_word.perimeter <= perim_ext[PERIM_W-1:0];
      res_word.area      <= area_ext[AREA_W-1:0];
    end
  end

endmodule

// File: test/triangle_perimeter_area_core_test.sv
// self-checking testbench for the triangle perimeter and heron area core
module triangle_perimeter_area_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY         = 63;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int FRAC_BITS_SHIFT = 10;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                tri_valid = 1'b0;
  logic                tri_stall;
  trpa_pkg::tri_word_t tri_word = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  trpa_pkg::res_word_t res_word;

  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  errors = 0;
  int                  cycles = 0;
  trpa_pkg::res_word_t expected_results[$];

  triangle_perimeter_area_core dut (
    .clk(clk), .rst(rst),
    .tri_valid(tri_valid), .tri_stall(tri_stall), .tri_word(tri_word),
    .res_valid(res_valid), .res_stall(res_stall), .res_word(res_word)
  );

  always #2 clk = ~clk;

  // floor square root of a 128-bit value, one bit at a time
  function automatic logic [63:0] floor_root(logic [127:0] x);
    logic [63:0]  r;
    logic [63:0]  c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if ({64'd0, c} * {64'd0, c} <= x) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] side_len(logic signed [15:0] x0, logic signed [15:0] y0,
                                           logic signed [15:0] x1, logic signed [15:0] y1);
    longint dx;
    longint dy;
    dx = longint'(x0) - longint'(x1);
    dy = longint'(y0) - longint'(y1);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return floor_root(128'(dx * dx + dy * dy));
  endfunction

  // perimeter and heron area of one triangle
  function automatic trpa_pkg::res_word_t triangle_result(trpa_pkg::tri_word_t t);
    trpa_pkg::res_word_t r;
    longint      a;
    longint      b;
    longint      c;
    longint      s;
    longint      fa;
    longint      fb;
    longint      fc;
    logic        neg;
    logic [127:0] prod;
    a = side_len(t.first_x, t.first_y, t.second_x, t.second_y);
    b = side_len(t.second_x, t.second_y, t.third_x, t.third_y);
    c = side_len(t.third_x, t.third_y, t.first_x, t.first_y);
    s = a + b + c;
    fa = s - 2 * a;
    fb = s - 2 * b;
    fc = s - 2 * c;
    neg = (fa < 0) ^ (fb < 0) ^ (fc < 0);
    r.perimeter = s[trpa_pkg::PERIM_W-1:0];
    r.area = '0;
    if (!neg && s != 0 && fa != 0 && fb != 0 && fc != 0) begin
      if (fa < 0) fa = -fa;
      if (fb < 0) fb = -fb;
      if (fc < 0) fc = -fc;
      prod = 128'(s * fa) * 128'(fb * fc);
      r.area = trpa_pkg::AREA_W'(floor_root(prod) >> (FRAC_BITS_SHIFT));
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // send one triangle word and record its expected result
  task automatic send_triangle(trpa_pkg::tri_word_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      tri_valid <= 1'b0;
      @(posedge clk);
    end
    tri_valid <= 1'b1;
    tri_word  <= t;
    expected_results.push_back(triangle_result(t));
    do @(posedge clk); while (tri_stall);
  endtask

  function automatic trpa_pkg::tri_word_t random_triangle();
    trpa_pkg::tri_word_t t;
    int        span;
    t = trpa_pkg::tri_word_t'({$urandom, $urandom, $urandom});
    // mostly keep vertices near each other so the area has a chance to be nonzero
    if ($urandom_range(3) != 0) begin
      span = 1 << $urandom_range(15, 2);
      t.second_x = t.first_x + $signed(16'($urandom_range(span - 1)));
      t.second_y = t.first_y + $signed(16'($urandom_range(span - 1)));
      t.third_x  = t.first_x - $signed(16'($urandom_range(span - 1)));
      t.third_y  = t.first_y + $signed(16'($urandom_range(span - 1)));
    end
    return t;
  endfunction

  // receiver stall and result checking
  always @(posedge clk) begin
    trpa_pkg::res_word_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (res_word.perimeter !== want.perimeter)
          report_mismatch("perimeter", longint'(res_word.perimeter),
                          longint'(want.perimeter));
        if (res_word.area !== want.area)
          report_mismatch("area", longint'(res_word.area), longint'(want.area));
      end
    end
    res_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic test_directed();
    trpa_pkg::tri_word_t t;
    // all zero: degenerate point triangle
    send_triangle('0);
    // extremes of every field, then alternating bit patterns
    send_triangle('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff});
    send_triangle('{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    send_triangle('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    send_triangle('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    send_triangle('{16'shffff, 16'sh0000, 16'sh5555, 16'shaaaa, 16'sh0000, 16'shffff});
    // right triangle 3-4-5
    send_triangle('{16'sh0000, 16'sh0000, 16'sh0300, 16'sh0000, 16'sh0000, 16'sh0400});
    // collinear points: degenerate
    send_triangle('{16'sh0100, 16'sh0100, 16'sh0200, 16'sh0200, 16'sh0300, 16'sh0300});
    // two coincident vertices
    send_triangle('{16'sh1000, 16'shf000, 16'sh1000, 16'shf000, 16'sh2000, 16'sh0000});
    // tiny slivers where truncation may push the product negative
    send_triangle('{16'sh0000, 16'sh0000, 16'sh0001, 16'sh0001, 16'sh0002, 16'sh0001});
    send_triangle('{16'sh0000, 16'sh0000, 16'sh0003, 16'sh0001, 16'sh0006, 16'sh0003});
    send_triangle('{16'sh0000, 16'sh0000, 16'sh7fff, 16'sh0001, 16'sh8000, 16'sh0000});
    for (int i = 0; i < 8; i++) begin
      t.first_x = 16'($urandom_range(3)); t.first_y = 16'($urandom_range(3));
      t.second_x = 16'($urandom_range(3)); t.second_y = 16'($urandom_range(3));
      t.third_x = 16'($urandom_range(3)); t.third_y = 16'($urandom_range(3));
      send_triangle(t);
    end
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_triangle(random_triangle());
  endtask

  task automatic drain();
    tri_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 33; recv_idle_pct = 70;
    test_directed();
    test_random(170);
    send_idle_pct = 70; recv_idle_pct = 33;
    test_random(170);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(170);
    drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: triangle_perimeter_area_core.f
hw/rtl/trpa_pkg.sv
hw/rtl/trpa_sqrt_cell.sv
hw/rtl/triangle_perimeter_area_core.sv
test/triangle_perimeter_area_core_test.sv
